// ===== sv/point_in_polygon_crossing_test_defines.svh =====
// Assertion macros used by the checker file of the crossing-number block.
// Depends on nothing; included by bare file name.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PIPCT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("pipct same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PIPCT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("pipct next-cycle check failed");

`endif

// ===== sv/pipct_pkg.sv =====
// Package for the point-in-polygon crossing-number block: widths, angle
// constants and the structs passed between its modules. Depends on nothing.
`default_nettype none

package pipct_pkg;

	localparam int CW    = 32;            // longitude width
	localparam int FB    = 29;            // fraction bits
	localparam int LATW  = CW - 1;        // latitude width
	localparam int DPW   = LATW + 1;      // latitude difference width
	localparam int DLONP = CW + 1;        // point longitude difference width
	localparam int DLW   = ((CW > FB + 3) ? CW : FB + 3) + 2; // wrapped edge dlon width
	localparam int PW    = DLW + DPW;     // product width
	localparam int PDW   = PW + 1;        // product difference width

	localparam logic [63:0] PI_Q62     = 64'hC90FDAA22168C234;
	localparam logic [63:0] PI_FIX     = (PI_Q62 + (64'd1 << (61 - FB))) >> (62 - FB);
	localparam logic [63:0] TWO_PI_FIX = (PI_Q62 + (64'd1 << (60 - FB))) >> (61 - FB);
	localparam logic signed [DLW-1:0] PI_D     = DLW'(PI_FIX);
	localparam logic signed [DLW-1:0] TWO_PI_D = DLW'(TWO_PI_FIX);

	localparam logic [1:0] TALLY_ZERO = 2'd0;
	localparam logic [1:0] TALLY_ONE  = 2'd1;
	localparam logic [1:0] TALLY_MAX  = 2'd3;

	typedef struct packed {
		logic signed [LATW-1:0] lat;
		logic signed [CW-1:0]   lon;
	} coord_t;

	typedef struct packed {
		coord_t p1;
		coord_t p2;
	} edge_t;

	typedef struct packed {
		logic valid;
		logic restart;
		logic edge_a_on;
		logic last;
		logic degen;
	} ctl_t;

endpackage

`default_nettype wire

// ===== sv/pipct_front.sv =====
// Input stage: takes a vertex word, keeps the polygon state and registers
// the point, both edges and the control bits. Depends on pipct_pkg.
`default_nettype none

module pipct_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [pipct_pkg::LATW-1:0] point_lat,
	input  logic signed [pipct_pkg::CW-1:0]   point_lon,
	input  logic signed [pipct_pkg::LATW-1:0] vert_lat,
	input  logic signed [pipct_pkg::CW-1:0]   vert_lon,
	input  logic                             first_vertex,
	input  logic                             last_vertex,
	output pipct_pkg::ctl_t                  ctl_s1,
	output pipct_pkg::coord_t                pt_s1,
	output pipct_pkg::edge_t                 edge_a_s1,
	output pipct_pkg::edge_t                 edge_b_s1
);

	pipct_pkg::coord_t held_q, start_q, prior_q;
	logic [1:0]        tally_q;

	logic              acc, restart;
	pipct_pkg::coord_t vert, pt_new, start_new;
	logic [1:0]        tally_new;

	always_comb begin
		acc       = en && in_valid;
		restart   = first_vertex || (tally_q == pipct_pkg::TALLY_ZERO);
		vert.lat  = vert_lat;
		vert.lon  = vert_lon;
		if (first_vertex) begin
			pt_new.lat = point_lat;
			pt_new.lon = point_lon;
		end else begin
			pt_new = held_q;
		end
		start_new = restart ? vert : start_q;
		if (restart) begin
			tally_new = pipct_pkg::TALLY_ONE;
		end else if (tally_q == pipct_pkg::TALLY_MAX) begin
			tally_new = pipct_pkg::TALLY_MAX;
		end else begin
			tally_new = tally_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			start_q <= '0;
			prior_q <= '0;
			tally_q <= pipct_pkg::TALLY_ZERO;
			ctl_s1  <= '0;
		end else begin
			if (acc) begin
				held_q  <= pt_new;
				start_q <= start_new;
				prior_q <= vert;
				tally_q <= last_vertex ? pipct_pkg::TALLY_ZERO : tally_new;
			end
			if (en) begin
				ctl_s1.valid     <= acc;
				ctl_s1.restart   <= restart;
				ctl_s1.edge_a_on <= !restart;
				ctl_s1.last      <= last_vertex;
				ctl_s1.degen     <= (tally_new != pipct_pkg::TALLY_MAX);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pt_s1        <= pt_new;
			edge_a_s1.p1 <= prior_q;
			edge_a_s1.p2 <= vert;
			edge_b_s1.p1 <= vert;
			edge_b_s1.p2 <= start_new;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pipct_edge.sv =====
// One edge test: orders ends, checks the latitude span, wraps dlon, then
// forms both cross-product terms and their sign. Depends on pipct_pkg.
`default_nettype none

module pipct_edge (
	input  logic              clk,
	input  logic              en,
	input  pipct_pkg::coord_t pt_s1,
	input  pipct_pkg::edge_t  edge_s1,
	output logic              cnt
);

	pipct_pkg::coord_t a, b;
	logic signed [pipct_pkg::DLW-1:0] dl_raw, dl_wrap;
	logic                             span;

	logic                               span_s2, span_s3;
	logic signed [pipct_pkg::DLW-1:0]   dlon_s2;
	logic signed [pipct_pkg::DPW-1:0]   dpl_s2, dblat_s2;
	logic signed [pipct_pkg::DLONP-1:0] dplon_s2;
	logic signed [pipct_pkg::PW-1:0]    prod_a_s3, prod_b_s3;
	logic signed [pipct_pkg::PDW-1:0]   diff;

	always_comb begin
		if (edge_s1.p1.lat < edge_s1.p2.lat) begin
			a = edge_s1.p1;
			b = edge_s1.p2;
		end else begin
			a = edge_s1.p2;
			b = edge_s1.p1;
		end
		span   = (pt_s1.lat > a.lat) && (pt_s1.lat <= b.lat);
		dl_raw = pipct_pkg::DLW'(b.lon) - pipct_pkg::DLW'(a.lon);
		if (dl_raw > pipct_pkg::PI_D || dl_raw < -pipct_pkg::PI_D) begin
			dl_wrap = dl_raw[pipct_pkg::DLW-1] ? dl_raw + pipct_pkg::TWO_PI_D
			                                   : dl_raw - pipct_pkg::TWO_PI_D;
		end else begin
			dl_wrap = dl_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s2   <= span;
			dlon_s2   <= dl_wrap;
			dpl_s2    <= pipct_pkg::DPW'(pt_s1.lat) - pipct_pkg::DPW'(a.lat);
			dblat_s2  <= pipct_pkg::DPW'(b.lat) - pipct_pkg::DPW'(a.lat);
			dplon_s2  <= pipct_pkg::DLONP'(pt_s1.lon) - pipct_pkg::DLONP'(a.lon);
			span_s3   <= span_s2;
			prod_a_s3 <= pipct_pkg::PW'(dlon_s2) * pipct_pkg::PW'(dpl_s2);
			prod_b_s3 <= pipct_pkg::PW'(dblat_s2) * pipct_pkg::PW'(dplon_s2);
		end
	end

	always_comb begin
		diff = pipct_pkg::PDW'(prod_a_s3) - pipct_pkg::PDW'(prod_b_s3);
		cnt  = span_s3 && !diff[pipct_pkg::PDW-1] && (diff != '0);
	end

endmodule

`default_nettype wire

// ===== sv/pipct_result.sv =====
// Control delay line, crossing parity and the result register.
// Depends on pipct_pkg.
`default_nettype none

module pipct_result (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  pipct_pkg::ctl_t ctl_s1,
	input  logic            cnt_a,
	input  logic            cnt_b,
	output logic            out_valid,
	output logic            inside_res,
	output logic            degenerate
);

	pipct_pkg::ctl_t ctl_s2, ctl_s3;
	logic            parity_q;
	logic            par_next;

	always_comb begin
		par_next = (ctl_s3.restart ? 1'b0 : parity_q)
		         ^ (ctl_s3.edge_a_on & cnt_a)
		         ^ (ctl_s3.last & cnt_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2     <= '0;
			ctl_s3     <= '0;
			parity_q   <= 1'b0;
			out_valid  <= 1'b0;
			inside_res <= 1'b0;
			degenerate <= 1'b0;
		end else if (en) begin
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			out_valid <= ctl_s3.valid && ctl_s3.last;
			if (ctl_s3.valid) begin
				parity_q   <= par_next;
				inside_res <= par_next && !ctl_s3.degen;
				degenerate <= ctl_s3.degen;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/point_in_polygon_crossing_test.sv =====
// Top level of the streaming point-in-polygon crossing-number test.
// Depends on pipct_pkg, pipct_front, pipct_edge and pipct_result.
//
//   channel | handshake           | payload
//   in      | in_valid, in_ready  | point_lat, point_lon, vert_lat, vert_lon,
//           |                     | first_vertex, last_vertex
//   out     | out_valid, out_ready| inside_res, degenerate
//
// One vertex word per cycle unless a held result stalls; a last vertex yields
// its result via the input register, difference stage, multiplier stage and result.
// The last vertex tests its edge and the closing edge on edge units u_edge_a and u_edge_b.
// A held result stalls every stage and drops in_ready until it is taken.
// Reset clears the polygon state, parity and all valid bits at once.
`default_nettype none

module point_in_polygon_crossing_test (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [pipct_pkg::LATW-1:0] point_lat,
	input  logic signed [pipct_pkg::CW-1:0]   point_lon,
	input  logic signed [pipct_pkg::LATW-1:0] vert_lat,
	input  logic signed [pipct_pkg::CW-1:0]   vert_lon,
	input  logic                             first_vertex,
	input  logic                             last_vertex,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             inside_res,
	output logic                             degenerate
);

	logic              en, cnt_a, cnt_b;
	pipct_pkg::ctl_t   ctl_s1;
	pipct_pkg::coord_t pt_s1;
	pipct_pkg::edge_t  edge_a_s1, edge_b_s1;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	pipct_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.point_lat    (point_lat),
		.point_lon    (point_lon),
		.vert_lat     (vert_lat),
		.vert_lon     (vert_lon),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.ctl_s1       (ctl_s1),
		.pt_s1        (pt_s1),
		.edge_a_s1    (edge_a_s1),
		.edge_b_s1    (edge_b_s1)
	);

	pipct_edge u_edge_a (
		.clk     (clk),
		.en      (en),
		.pt_s1   (pt_s1),
		.edge_s1 (edge_a_s1),
		.cnt     (cnt_a)
	);

	pipct_edge u_edge_b (
		.clk     (clk),
		.en      (en),
		.pt_s1   (pt_s1),
		.edge_s1 (edge_b_s1),
		.cnt     (cnt_b)
	);

	pipct_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_s1     (ctl_s1),
		.cnt_a      (cnt_a),
		.cnt_b      (cnt_b),
		.out_valid  (out_valid),
		.inside_res (inside_res),
		.degenerate (degenerate)
	);

endmodule

`default_nettype wire

// ===== sv/pipct_checker.sv =====
// Port-level checker for the crossing-number block, bound to the top level.
// Depends on pipct_pkg and point_in_polygon_crossing_test_defines.svh.
`default_nettype none
`include "point_in_polygon_crossing_test_defines.svh"

module pipct_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic signed [pipct_pkg::LATW-1:0] point_lat,
	input logic signed [pipct_pkg::CW-1:0]   point_lon,
	input logic signed [pipct_pkg::LATW-1:0] vert_lat,
	input logic signed [pipct_pkg::CW-1:0]   vert_lon,
	input logic                             first_vertex,
	input logic                             last_vertex,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             inside_res,
	input logic                             degenerate
);

	logic [2*pipct_pkg::LATW+2*pipct_pkg::CW+1:0] in_word;

	assign in_word = {point_lat, point_lon, vert_lat, vert_lon, first_vertex, last_vertex};

	`PIPCT_ASSERT_IMP(a_flags_exclusive, clk, arst_n, out_valid, !(inside_res && degenerate))
	`PIPCT_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, out_valid && !out_ready, !in_ready)
	`PIPCT_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)
	`PIPCT_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({inside_res, degenerate}))
	`PIPCT_ASSERT_NXT(a_in_stable, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_word))

endmodule

bind point_in_polygon_crossing_test pipct_checker u_pipct_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for point_in_polygon_crossing_test: streams polygon vertex words and checks
// each inside/degenerate word against a crossing-number scoreboard held in this file.
// Depends on pipct_pkg and the block's RTL.

module testbench;

	localparam int FB   = pipct_pkg::FB;
	localparam int CW   = pipct_pkg::CW;
	localparam int LATW = pipct_pkg::LATW;
	localparam logic [1:0] TALLY_ZERO = pipct_pkg::TALLY_ZERO;
	localparam logic [1:0] TALLY_ONE  = pipct_pkg::TALLY_ONE;
	localparam logic [1:0] TALLY_MAX  = pipct_pkg::TALLY_MAX;

	localparam int CLK_PERIOD = 20;
	localparam longint LAT_LIMIT = 843314857;
	localparam longint LON_LIMIT = 1686629713;
	localparam logic [63:0] HALF_TURN_Q62 = 64'hC90FDAA22168C234;
	localparam longint HALF_TURN = longint'((HALF_TURN_Q62 + (64'd1 << (61 - FB))) >> (62 - FB));
	localparam longint FULL_TURN = longint'((HALF_TURN_Q62 + (64'd1 << (60 - FB))) >> (61 - FB));
	localparam int ITEM_TARGET = 1250;
	localparam int CALM_TAIL = 200;
	localparam int RESULT_LATENCY = 4;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [LATW-1:0] plat;
		logic signed [CW-1:0]   plon;
		logic signed [LATW-1:0] vlat;
		logic signed [CW-1:0]   vlon;
		bit                     first;
		bit                     last;
	} vertex_word_t;

	typedef struct {
		bit enclosed;
		bit degen;
	} polygon_verdict_t;

	class crossing_scoreboard;
		longint held_lat, held_lon, open_lat, open_lon, prev_lat, prev_lon;
		bit parity;
		logic [1:0] tally;
		polygon_verdict_t pending[$];
		int errors;

		function new();
			held_lat = 0; held_lon = 0; open_lat = 0; open_lon = 0;
			prev_lat = 0; prev_lon = 0;
			parity = 1'b0;
			tally = TALLY_ZERO;
			errors = 0;
		endfunction

		task report(string what);
			$display("[%0t] %s", $time, what);
			errors++;
		endtask

		function bit crosses(longint lat1, longint lon1, longint lat2, longint lon2);
			longint alat, alon, blat, blon, dlon;
			logic signed [127:0] run, rise, up, over, lhs, rhs;
			if (lat1 < lat2) begin
				alat = lat1; alon = lon1; blat = lat2; blon = lon2;
			end else begin
				alat = lat2; alon = lon2; blat = lat1; blon = lon1;
			end
			if (held_lat <= alat || held_lat > blat)
				return 1'b0;
			dlon = blon - alon;
			if (dlon > HALF_TURN || dlon < -HALF_TURN)
				dlon = (dlon > 0) ? dlon - FULL_TURN : dlon + FULL_TURN;
			run = dlon;
			up = held_lat - alat;
			rise = blat - alat;
			over = held_lon - alon;
			lhs = run * up;
			rhs = rise * over;
			return (lhs - rhs) > 0;
		endfunction

		function void note_vertex(vertex_word_t w);
			longint vlat, vlon;
			polygon_verdict_t v;
			vlat = w.vlat;
			vlon = w.vlon;
			if (w.first) begin
				held_lat = w.plat;
				held_lon = w.plon;
			end
			if (w.first || tally == TALLY_ZERO) begin
				open_lat = vlat;
				open_lon = vlon;
				parity = 1'b0;
				tally = TALLY_ONE;
			end else begin
				if (crosses(prev_lat, prev_lon, vlat, vlon))
					parity ^= 1'b1;
				if (tally != TALLY_MAX)
					tally++;
			end
			prev_lat = vlat;
			prev_lon = vlon;
			if (w.last) begin
				if (crosses(vlat, vlon, open_lat, open_lon))
					parity ^= 1'b1;
				v.degen = (tally != TALLY_MAX);
				v.enclosed = !v.degen && parity;
				pending.push_back(v);
				tally = TALLY_ZERO;
			end
		endfunction

		task check_result(bit enclosed, bit degen);
			polygon_verdict_t v;
			if (pending.size() == 0) begin
				report($sformatf("result word with nothing pending: inside %0b degenerate %0b",
					enclosed, degen));
			end else begin
				v = pending.pop_front();
				if (enclosed !== v.enclosed)
					report($sformatf("inside_res is %0b, want %0b", enclosed, v.enclosed));
				if (degen !== v.degen)
					report($sformatf("degenerate is %0b, want %0b", degen, v.degen));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [LATW-1:0] point_lat;
	logic signed [CW-1:0]   point_lon;
	logic signed [LATW-1:0] vert_lat;
	logic signed [CW-1:0]   vert_lon;
	logic first_vertex;
	logic last_vertex;
	logic out_valid;
	logic out_ready;
	logic inside_res;
	logic degenerate;

	crossing_scoreboard sb;
	int words_sent;
	bit calm;
	bit drained_mid;
	int cycles;

	point_in_polygon_crossing_test DUT (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic vertex(longint plat, longint plon, longint vlat, longint vlon,
		bit first, bit last);
		vertex_word_t w;
		w.plat = LATW'(plat);
		w.plon = CW'(plon);
		w.vlat = LATW'(vlat);
		w.vlon = CW'(vlon);
		w.first = first;
		w.last = last;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_lat <= w.plat;
		point_lon <= w.plon;
		vert_lat <= w.vlat;
		vert_lon <= w.vlon;
		first_vertex <= w.first;
		last_vertex <= w.last;
		do @(posedge clk); while (!in_ready);
		sb.note_vertex(w);
		words_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	function automatic longint spread(longint s);
		return longint'($urandom_range(0, 32'(2 * s))) - s;
	endfunction

	task automatic directed_vertices();
		// single vertex, then two vertices: both degenerate
		vertex(0, 0, 0, 0, 1, 1);
		vertex(LAT_LIMIT / 2, LON_LIMIT / 2, -LAT_LIMIT, 0, 1, 0);
		vertex(0, 0, LAT_LIMIT, 0, 0, 1);
		// square on the range corners around the origin
		vertex(0, 0, -LAT_LIMIT, -LON_LIMIT, 1, 0);
		vertex(0, 0, -LAT_LIMIT, LON_LIMIT, 0, 0);
		vertex(0, 0, LAT_LIMIT, LON_LIMIT, 0, 0);
		vertex(0, 0, LAT_LIMIT, -LON_LIMIT, 0, 1);
		// no open polygon: start one and keep the held point
		vertex(LAT_LIMIT, LON_LIMIT, -LAT_LIMIT, -LON_LIMIT, 0, 0);
		vertex(-LAT_LIMIT, -LON_LIMIT, LAT_LIMIT, 0, 0, 0);
		vertex(0, 0, -LAT_LIMIT, LON_LIMIT, 0, 1);
		// point latitude equal to a vertex latitude
		vertex(0, 0, 0, -5, 1, 0);
		vertex(0, 0, 10, 5, 0, 0);
		vertex(0, 0, -10, 5, 0, 1);
		// edges across the antimeridian
		vertex(0, LON_LIMIT - 10, -100, LON_LIMIT - 100, 1, 0);
		vertex(0, 0, -100, 100 - LON_LIMIT, 0, 0);
		vertex(0, 0, 100, 100 - LON_LIMIT, 0, 0);
		vertex(0, 0, 100, LON_LIMIT - 100, 0, 1);
		// extreme field codes
		vertex(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1, 1, 0);
		vertex(-1, -1, -(64'sd1 << 30), -(64'sd1 << 31), 0, 0);
		vertex(0, 0, -1, -1, 0, 1);
		// restart inside an open polygon
		vertex(5, 5, -50, -50, 1, 0);
		vertex(0, 0, 50, -50, 0, 0);
		vertex(-5, 5, 50, 50, 1, 0);
		vertex(0, 0, -50, 50, 0, 0);
		vertex(0, 0, 0, 60, 0, 1);
	endtask

	task automatic random_polygon();
		int n, kind, pick, q;
		longint plat, plon, slat, slon, vlat, vlon, olat, olon;
		bit first, last;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			n = 1;
		else if (pick == 1)
			n = 2;
		else if (pick <= 16)
			n = $urandom_range(3, 8);
		else if (pick <= 18)
			n = $urandom_range(9, 16);
		else
			n = $urandom_range(17, 40);
		kind = $urandom_range(0, 9);
		case ($urandom_range(0, 4))
			0: slat = 3;
			1: slat = 64'sd1 << 12;
			2: slat = 64'sd1 << 20;
			3: slat = 64'sd1 << 27;
			default: slat = LAT_LIMIT;
		endcase
		if (kind == 5 || kind == 6)
			slat = $urandom_range(0, 4);
		slon = 2 * slat;
		plat = spread(LAT_LIMIT);
		plon = spread(LON_LIMIT);
		if (kind == 7)
			plon = ($urandom_range(0, 1) ? LON_LIMIT : -LON_LIMIT) - spread(1000);
		if (kind == 9) begin
			plat = longint'($urandom);
			plon = longint'($urandom);
		end
		for (int i = 0; i < n; i++) begin
			if (kind <= 4 || kind == 7) begin
				q = (i * 4) / n;
				olat = $urandom_range(0, 32'(slat));
				olon = $urandom_range(0, 32'(slon));
				vlat = (q < 2) ? plat + olat : plat - olat;
				vlon = (q == 0 || q == 3) ? plon + olon : plon - olon;
				if (kind == 7 && vlon > LON_LIMIT)
					vlon -= 2 * LON_LIMIT;
				else if (kind == 7 && vlon < -LON_LIMIT)
					vlon += 2 * LON_LIMIT;
			end else if (kind <= 6) begin
				vlat = plat + spread(slat);
				vlon = plon + spread(slon);
			end else if (kind == 8) begin
				vlat = spread(LAT_LIMIT);
				vlon = spread(LON_LIMIT);
			end else begin
				vlat = longint'($urandom);
				vlon = longint'($urandom);
			end
			first = (i == 0) && ($urandom_range(0, 11) != 0);
			last = (i == n - 1) && ($urandom_range(0, 11) != 0);
			if (first)
				vertex(plat, plon, vlat, vlon, first, last);
			else
				vertex(longint'($urandom), longint'($urandom), vlat, vlon, first, last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && out_ready)
			sb.check_result(inside_res, degenerate);
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, ($urandom_range(0, 3) == 0) ? 60 : 12)) @(posedge clk);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		sb = new();
		words_sent = 0;
		calm = 1'b0;
		drained_mid = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		point_lat <= '0;
		point_lon <= '0;
		vert_lat <= '0;
		vert_lon <= '0;
		first_vertex <= 1'b0;
		last_vertex <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		directed_vertices();
		hold_until_drained();
		while (words_sent < ITEM_TARGET) begin
			if (!drained_mid && words_sent >= ITEM_TARGET / 2) begin
				hold_until_drained();
				drained_mid = 1'b1;
			end
			calm = (words_sent >= ITEM_TARGET - CALM_TAIL);
			random_polygon();
		end
		hold_until_drained();
		repeat (RESULT_LATENCY) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
